// ===== rtl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue core.
// Operation and status codes, the cell word and the cell command.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic              occ;
    logic              mark;
    logic [DATA_W-1:0] data;
  } cell_word_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_R,
    CMD_PUSH_B,
    CMD_SHIFT_L,
    CMD_POP_B,
    CMD_MARK,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/dq_if.sv =====
// Valid/ready channels of the double-ended queue core: request and result.
// Depends on nothing; widths follow the field definitions.
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dq_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value_res;
  logic               last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// Double-ended queue core: the front entry sits in cell 0 of a chain of DEPTH
// cells, the back entry in the last occupied cell. Pushes and pops are
// accepted every cycle while no read-all runs and the result register is
// free or being emptied; each is answered in the cycle after acceptance.
// A read-all first marks the last entry to arm the chain, then returns the
// entries one by one, rotating the chain past cell 0 and returning it to its
// original order. No clearing pass after reset.
// Depends on dq_pkg, dq_if and dq_cell.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dq_req_if.sink     in_req,
  dq_res_if.source   out_res
);
  import dq_pkg::*;

  cell_word_t        cw [DEPTH];
  cell_word_t        lw [DEPTH];
  cell_word_t        rw [DEPTH];
  logic [DEPTH-1:0]  tail;
  cell_cmd_t         cmd;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              last_r, last_nxt;
  logic              load;
  logic              out_free;
  logic              acc;
  logic              full;
  logic              empty;
  logic [DATA_W-1:0] tail_data;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign lw[g] = '{occ: 1'b1, mark: 1'b0, data: in_req.value};
      end else begin : g_mid
        assign lw[g] = cw[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign rw[g] = '0;
      end else begin : g_inner
        assign rw[g] = cw[g+1];
      end
      dq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (in_req.value),
        .left_word  (lw[g]),
        .right_word (rw[g]),
        .head_word  (cw[0]),
        .word_o     (cw[g]),
        .tail_o     (tail[g])
      );
    end
  endgenerate

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cw[i].data & {DATA_W{tail[i]}});
    end
  end

  assign full     = cw[DEPTH-1].occ;
  assign empty    = !cw[0].occ;
  assign out_free = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_req.valid && in_req.ready;

  always_comb begin
    cmd        = CMD_HOLD;
    load       = 1'b0;
    status_nxt = STAT_OK;
    value_nxt  = '0;
    last_nxt   = 1'b1;
    state_nxt  = state_r;
    if (state_r == S_READ) begin
      if (out_free) begin
        load      = 1'b1;
        value_nxt = cw[0].data;
        last_nxt  = cw[0].mark;
        cmd       = CMD_ROTATE;
        if (cw[0].mark) begin
          state_nxt = S_IDLE;
        end
      end
    end else if (acc) begin
      case (in_req.operation)
        OP_PUSH_FRONT: begin
          load = 1'b1;
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            cmd = CMD_SHIFT_R;
          end
        end
        OP_PUSH_BACK: begin
          load = 1'b1;
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            cmd = CMD_PUSH_B;
          end
        end
        OP_POP_FRONT: begin
          load = 1'b1;
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            cmd       = CMD_SHIFT_L;
            value_nxt = cw[0].data;
          end
        end
        OP_POP_BACK: begin
          load = 1'b1;
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            cmd       = CMD_POP_B;
            value_nxt = tail_data;
          end
        end
        OP_READ_ALL: begin
          if (empty) begin
            load       = 1'b1;
            status_nxt = STAT_EMPTY;
          end else begin
            cmd       = CMD_MARK;
            state_nxt = S_READ;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.status    = status_r;
  assign out_res.value_res = signed'(value_r);
  assign out_res.last      = last_r;

endmodule

`default_nettype wire

// ===== rtl/dq_cell.sv =====
// One cell of the entry chain: holds one entry, its occupancy and read mark.
// Takes data from its neighbours under a broadcast command. Uses dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_pkg::cell_cmd_t          cmd,
  input  wire logic [dq_pkg::DATA_W-1:0]  push_value,
  input  wire dq_pkg::cell_word_t         left_word,
  input  wire dq_pkg::cell_word_t         right_word,
  input  wire dq_pkg::cell_word_t         head_word,
  output dq_pkg::cell_word_t              word_o,
  output logic                            tail_o
);
  import dq_pkg::*;

  logic              occ_r, occ_nxt;
  logic              mark_r, mark_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    occ_nxt  = occ_r;
    mark_nxt = mark_r;
    data_nxt = data_r;
    case (cmd)
      CMD_SHIFT_R: begin
        occ_nxt  = left_word.occ;
        data_nxt = left_word.data;
      end
      CMD_PUSH_B: begin
        if (!occ_r && left_word.occ) begin
          occ_nxt  = 1'b1;
          data_nxt = push_value;
        end
      end
      CMD_SHIFT_L: begin
        occ_nxt  = right_word.occ;
        data_nxt = right_word.data;
      end
      CMD_POP_B: begin
        if (occ_r && !right_word.occ) begin
          occ_nxt = 1'b0;
        end
      end
      CMD_MARK: begin
        mark_nxt = occ_r && !right_word.occ;
      end
      CMD_ROTATE: begin
        if (right_word.occ) begin
          data_nxt = right_word.data;
          mark_nxt = right_word.mark;
        end else if (occ_r) begin
          data_nxt = head_word.data;
          mark_nxt = head_word.mark;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      mark_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word_o = '{occ: occ_r, mark: mark_r, data: data_r};
  assign tail_o = occ_r && !right_word.occ;

endmodule

`default_nettype wire

// ===== rtl/dq_checker.sv =====
// Port-level checks for the double-ended queue core, bound to its top level.
// Uses dq_pkg for operation and status codes.
`timescale 1ns / 1ps
`default_nettype none

module dq_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_value_res,
  input wire logic        out_last
);
  import dq_pkg::*;

  logic in_acc;
  logic push_acc;
  logic pop_acc;

  assign in_acc   = in_valid && in_ready;
  assign push_acc = in_acc && (in_operation == OP_PUSH_FRONT ||
                               in_operation == OP_PUSH_BACK);
  assign pop_acc  = in_acc && (in_operation == OP_POP_FRONT ||
                               in_operation == OP_POP_BACK);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  a_no_req_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
    push_acc |=> out_valid && out_last && out_value_res == '0 && out_status != STAT_EMPTY)
    else $error("push not answered in one cycle");

  a_pop_answer: assert property (@(posedge clk) disable iff (!rst_n)
    pop_acc |=> out_valid && out_last && out_status != STAT_FULL)
    else $error("pop not answered in one cycle");

  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == STAT_OK)
    else $error("non-final result without ok status");

endmodule

bind double_ended_queue_core dq_port_checker u_dq_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .in_operation  (in_req.operation),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_status    (out_res.status),
  .out_value_res (out_res.value_res),
  .out_last      (out_res.last)
);

`default_nettype wire

// ===== sim/dq_checker.sv =====
// Checker for the double-ended queue core: mirrors the queue in a ring store, predicts
// the answers to each accepted request and compares them with the results.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  input  logic                             req_ready,
  input  logic        [dq_pkg::OP_W-1:0]   req_operation,
  input  logic signed [dq_pkg::DATA_W-1:0] req_value,
  input  logic                             res_valid,
  input  logic                             res_ready,
  input  logic        [dq_pkg::STAT_W-1:0] res_status,
  input  logic signed [dq_pkg::DATA_W-1:0] res_value_res,
  input  logic                             res_last,
  output int unsigned                      pending,
  output int unsigned                      fail_count,
  output int unsigned                      results_seen,
  output int unsigned                      full_seen,
  output int unsigned                      empty_seen
);
  import dq_pkg::*;

  localparam int unsigned SLOTS = DEPTH_DEF;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
  } answer_t;

  answer_t                  awaited_answers[$];
  logic signed [DATA_W-1:0] ring [SLOTS];
  int unsigned              head_slot;
  int unsigned              live_count;
  int unsigned              fails;
  int unsigned              seen;
  int unsigned              fulls;
  int unsigned              empties;

  task automatic queue_answer(input logic [STAT_W-1:0] st,
                              input logic signed [DATA_W-1:0] v, input logic lst);
    answer_t a;
    a.status    = st;
    a.value_res = v;
    a.last      = lst;
    awaited_answers.push_back(a);
  endtask

  task automatic predict_request(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val);
    int unsigned k;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (live_count >= SLOTS) begin
          queue_answer(STAT_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + SLOTS - 1) % SLOTS;
            ring[head_slot] = val;
          end else begin
            ring[(head_slot + live_count) % SLOTS] = val;
          end
          live_count++;
          queue_answer(STAT_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (live_count == 0) begin
          queue_answer(STAT_EMPTY, '0, 1'b1);
        end else begin
          queue_answer(STAT_OK, ring[head_slot], 1'b1);
          head_slot = (head_slot + 1) % SLOTS;
          live_count--;
        end
      end
      OP_POP_BACK: begin
        if (live_count == 0) begin
          queue_answer(STAT_EMPTY, '0, 1'b1);
        end else begin
          live_count--;
          queue_answer(STAT_OK, ring[(head_slot + live_count) % SLOTS], 1'b1);
        end
      end
      OP_READ_ALL: begin
        if (live_count == 0) begin
          queue_answer(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < live_count; k++)
            queue_answer(STAT_OK, ring[(head_slot + k) % SLOTS], k + 1 == live_count);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      awaited_answers.delete();
      head_slot  = 0;
      live_count = 0;
      fails      = 0;
      seen       = 0;
      fulls      = 0;
      empties    = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (awaited_answers.size() == 0) begin
          $error("unexpected result: status %0d, value_res %0d, last %0d",
                 res_status, res_value_res, res_last);
          fails++;
        end else begin
          want = awaited_answers.pop_front();
          if (res_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_status);
            fails++;
          end
          if (res_value_res !== want.value_res) begin
            $error("value_res: expected %0d, got %0d", want.value_res, res_value_res);
            fails++;
          end
          if (res_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_last);
            fails++;
          end
          seen++;
          if (want.status == STAT_FULL) fulls++;
          if (want.status == STAT_EMPTY) empties++;
        end
      end
      if (req_valid && req_ready) predict_request(req_operation, req_value);
    end
    pending      <= awaited_answers.size();
    fail_count   <= fails;
    results_seen <= seen;
    full_seen    <= fulls;
    empty_seen   <= empties;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the double-ended queue core bench: clock, reset, request and result
// traffic with random idling, and the verdict. Depends on dq_pkg, dq_if,
// dq_checker and double_ended_queue_core.
`timescale 1ns / 1ps

module testbench;
  import dq_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dq_req_if req_ch ();
  dq_res_if res_ch ();

  int unsigned mirror_pending;
  int unsigned mirror_fails;
  int unsigned mirror_results;
  int unsigned mirror_fulls;
  int unsigned mirror_empties;
  int unsigned accepted_requests;
  bit          sender_burst;
  bit          receiver_burst;
  bit          hold_results;

  double_ended_queue_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  dq_checker mirror (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_operation (req_ch.operation),
    .req_value     (req_ch.value),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_status    (res_ch.status),
    .res_value_res (res_ch.value_res),
    .res_last      (res_ch.last),
    .pending       (mirror_pending),
    .fail_count    (mirror_fails),
    .results_seen  (mirror_results),
    .full_seen     (mirror_fulls),
    .empty_seen    (mirror_empties)
  );

  always #4 clk = ~clk;

  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
    accepted_requests++;
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror_pending != 0);
  endtask

  function automatic logic [OP_W-1:0] pick_operation(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return OP_READ_ALL + OP_W'($urandom_range(1, 3));
    if (roll < 12) return OP_READ_ALL;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // result side: random stalls, one long hold on request
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
        stall = receiver_burst ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        do @(posedge clk); while (!res_ch.valid && !hold_results);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  initial begin
    int unsigned       items;
    int unsigned       push_pct;
    logic [OP_W-1:0]   op;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_PUSH_FRONT;
    req_ch.value     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty answers, extremes of the value, undefined operations
    send_request(OP_POP_FRONT, 32'sh1234_5678);
    send_request(OP_POP_BACK, -32'sd1);
    send_request(OP_READ_ALL, '0);
    send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'sh8000_0000);
    send_request(OP_PUSH_BACK, '0);
    send_request(OP_PUSH_FRONT, -32'sd1);
    send_request(OP_READ_ALL, 32'sh5555_5555);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_READ_ALL + OP_W'(1), 32'shAAAA_AAAA);
    send_request(OP_READ_ALL + OP_W'(2), 32'sh5555_5555);
    send_request(OP_READ_ALL + OP_W'(3), -32'sd1);
    // fill to capacity, then overflow at both ends
    for (int i = 0; i < 14; i++)
      send_request((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
    send_request(OP_PUSH_FRONT, $urandom());
    send_request(OP_PUSH_BACK, $urandom());
    send_request(OP_READ_ALL, '0);
    wait_for_results();

    // hold the result side while requests keep coming
    hold_results = 1'b1;
    sender_burst = 1'b1;
    for (int i = 0; i < 24; i++) send_request(pick_operation(50), $urandom());
    wait_for_results();

    items = 0;
    while (items < RANDOM_ITEMS) begin
      case ((items / PHASE_ITEMS) % 3)
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      op = pick_operation(push_pct);
      send_request(op, $urandom());
      if (op <= OP_READ_ALL) begin
        items++;
        if (items % PHASE_ITEMS == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d checked results, %0d full and %0d empty answers.",
             accepted_requests, mirror_results, mirror_fulls, mirror_empties);
    if (mirror_fails == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
rtl/dq_checker.sv
sim/dq_checker.sv
sim/testbench.sv
